FILE: rtl/mbet_pkg.sv
// mbet_pkg: shared types, constants and helpers for the mandelbrot escape-time block
// fixed-point format constants, word structs, register indexes and coordinate saturation
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mbet_pkg;

	localparam int FRAC_BITS   = 28;
	localparam int COORD_WIDTH = 32;
	localparam int COUNT_WIDTH = 24;
	localparam int INDEX_WIDTH = 16;
	localparam int STEP_WIDTH  = COORD_WIDTH - 1;

	// multiplier operands carry one extra bit so unsigned steps stay positive
	localparam int MUL_WIDTH   = COORD_WIDTH + 1;
	localparam int PROD_WIDTH  = 2 * COORD_WIDTH;
	localparam int SUM_WIDTH   = PROD_WIDTH + 2;
	// |z|^2 >= 4 in a product with 2*FRAC_BITS fraction bits
	localparam int ESC_BIT     = 2 * FRAC_BITS + 2;

	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH  = 32;

	localparam logic [CFG_INDEX_WIDTH-1:0] REG_MAX_ITER  = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_RE_ORIGIN = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_RE_STEP   = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_IM_ORIGIN = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_IM_STEP   = 3'd4;

	localparam logic [COUNT_WIDTH-1:0]        MAX_ITER_RESET = 24'd1000;
	localparam logic signed [COORD_WIDTH-1:0] ORIGIN_RESET   = -32'sd536870912;
	localparam logic [STEP_WIDTH-1:0]         STEP_RESET     = 31'd262144;

	typedef struct packed {
		logic [INDEX_WIDTH-1:0] column;
		logic [INDEX_WIDTH-1:0] row;
	} pixel_t;

	typedef struct packed {
		logic [COUNT_WIDTH-1:0] iteration_count;
		logic                   escaped;
	} result_t;

	// clamp a wide signed value into the signed coordinate range
	function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
		input logic signed [SUM_WIDTH-1:0] v
	);
		logic signed [COORD_WIDTH-1:0] r;
		if ((&v[SUM_WIDTH-1:COORD_WIDTH-1]) || !(|v[SUM_WIDTH-1:COORD_WIDTH-1])) begin
			r = v[COORD_WIDTH-1:0];
		end else if (v[SUM_WIDTH-1]) begin
			r = {1'b1, {(COORD_WIDTH-1){1'b0}}};
		end else begin
			r = {1'b0, {(COORD_WIDTH-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/mandelbrot_escape_time.sv
// mandelbrot_escape_time: escape-time iteration for one pixel per word
// depends on mbet_pkg; one shared signed multiplier under a small sequencer
// Usage:
//   pixel channel (pixel_valid / pixel_stall / pixel) takes a column and row word.
//   result channel (result_valid / result_stall / result) returns one word per
//   pixel: iteration count and escaped flag.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes the limit,
//   origins and steps; cfg_ready is always high; the user must write only while idle,
//   which the block does not enforce. States MCX, MCY and CSET form c, then each
//   iteration of z = z*z + c runs through LOOP, UPD, SQX, SQY and the magnitude test,
//   and the finished word passes into the output register once the pixel escapes or
//   reaches the limit; the single multiplier forms x*y, x*x and y*y per iteration.
// Throughput: one pixel at a time; pixel_stall is high from acceptance until the
//   sequencer is idle again.
// A finished word sits in the output register while result_stall is high; the
//   next pixel may be taken meanwhile, but its result waits until the register frees.
// Reset clears the sequencer and output valid, and loads the default view
//   (limit 1000, origin -2.0, step 2^-10 on both axes).
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_time (
	input  wire                                     clk,
	input  wire                                     arst_n,
	input  wire                                     pixel_valid,
	output logic                                    pixel_stall,
	input  mbet_pkg::pixel_t                        pixel,
	output logic                                    result_valid,
	input  wire                                     result_stall,
	output mbet_pkg::result_t                       result,
	input  wire                                     cfg_valid,
	output logic                                    cfg_ready,
	input  wire  [mbet_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
	input  wire  [mbet_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MCX  = 3'd1;
	localparam logic [2:0] ST_MCY  = 3'd2;
	localparam logic [2:0] ST_CSET = 3'd3;
	localparam logic [2:0] ST_LOOP = 3'd4;
	localparam logic [2:0] ST_UPD  = 3'd5;
	localparam logic [2:0] ST_SQX  = 3'd6;
	localparam logic [2:0] ST_SQY  = 3'd7;
	localparam logic [2:0] ST_MAG  = 3'd0;

	localparam int CW = mbet_pkg::COORD_WIDTH;
	localparam int MW = mbet_pkg::MUL_WIDTH;
	localparam int PW = mbet_pkg::PROD_WIDTH;
	localparam int SW = mbet_pkg::SUM_WIDTH;
	localparam int NW = mbet_pkg::COUNT_WIDTH;

	// configuration
	logic [NW-1:0]                    max_iter_q;
	logic signed [CW-1:0]             re_origin_q;
	logic signed [CW-1:0]             im_origin_q;
	logic [mbet_pkg::STEP_WIDTH-1:0]  re_step_q;
	logic [mbet_pkg::STEP_WIDTH-1:0]  im_step_q;

	// sequencer and datapath
	logic [2:0]                       state_q;
	logic                             mag_q;
	logic                             done_q;
	logic                             done_esc_q;
	logic [mbet_pkg::INDEX_WIDTH-1:0] col_q;
	logic [mbet_pkg::INDEX_WIDTH-1:0] row_q;
	logic signed [CW-1:0]             cx_q;
	logic signed [CW-1:0]             cy_q;
	logic signed [CW-1:0]             x_q;
	logic signed [CW-1:0]             y_q;
	logic signed [PW-1:0]             xx_q;
	logic signed [PW-1:0]             yy_q;
	logic signed [PW-1:0]             p_q;
	logic [NW-1:0]                    count_q;

	logic                             result_valid_q;
	mbet_pkg::result_t                result_q;

	logic signed [MW-1:0]             mul_a;
	logic signed [MW-1:0]             mul_b;
	logic signed [2*MW-1:0]           prod;
	logic signed [SW-1:0]             p_ext;
	logic signed [SW-1:0]             diff;
	logic signed [SW-1:0]             nx_sum;
	logic signed [SW-1:0]             ny_sum;
	logic signed [SW-1:0]             cx_sum;
	logic signed [SW-1:0]             cy_sum;
	logic [PW:0]                      mag;
	logic                             idle;
	logic                             out_free;

	assign cfg_ready    = 1'b1;
	assign idle         = (state_q == ST_IDLE) && !mag_q && !done_q;
	assign pixel_stall  = !idle;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign out_free     = !result_valid_q || !result_stall;

	// shared multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (!mag_q) begin
			unique case (state_q)
				ST_MCX: begin
					mul_a = $signed({{(MW-mbet_pkg::INDEX_WIDTH){1'b0}}, col_q});
					mul_b = $signed({{(MW-mbet_pkg::STEP_WIDTH){1'b0}}, re_step_q});
				end
				ST_MCY: begin
					mul_a = $signed({{(MW-mbet_pkg::INDEX_WIDTH){1'b0}}, row_q});
					mul_b = $signed({{(MW-mbet_pkg::STEP_WIDTH){1'b0}}, im_step_q});
				end
				ST_LOOP: begin
					mul_a = {x_q[CW-1], x_q};
					mul_b = {y_q[CW-1], y_q};
				end
				ST_SQX: begin
					mul_a = {x_q[CW-1], x_q};
					mul_b = {x_q[CW-1], x_q};
				end
				ST_SQY: begin
					mul_a = {y_q[CW-1], y_q};
					mul_b = {y_q[CW-1], y_q};
				end
				default: begin
					mul_a = '0;
					mul_b = '0;
				end
			endcase
		end
	end

	assign prod   = mul_a * mul_b;
	assign p_ext  = {{(SW-PW){p_q[PW-1]}}, p_q};
	assign cx_sum = $signed({{(SW-CW){re_origin_q[CW-1]}}, re_origin_q}) + p_ext;
	assign cy_sum = $signed({{(SW-CW){im_origin_q[CW-1]}}, im_origin_q}) + p_ext;
	assign diff   = {{(SW-PW){xx_q[PW-1]}}, xx_q} - {{(SW-PW){yy_q[PW-1]}}, yy_q};
	assign nx_sum = (diff >>> mbet_pkg::FRAC_BITS) + $signed({{(SW-CW){cx_q[CW-1]}}, cx_q});
	assign ny_sum = (p_ext >>> (mbet_pkg::FRAC_BITS - 1)) +
		$signed({{(SW-CW){cy_q[CW-1]}}, cy_q});
	// both squares are non-negative
	assign mag    = {1'b0, xx_q} + {1'b0, p_q};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_iter_q  <= mbet_pkg::MAX_ITER_RESET;
			re_origin_q <= mbet_pkg::ORIGIN_RESET;
			im_origin_q <= mbet_pkg::ORIGIN_RESET;
			re_step_q   <= mbet_pkg::STEP_RESET;
			im_step_q   <= mbet_pkg::STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mbet_pkg::REG_MAX_ITER:  max_iter_q  <= cfg_data[NW-1:0];
				mbet_pkg::REG_RE_ORIGIN: re_origin_q <= $signed(cfg_data[CW-1:0]);
				mbet_pkg::REG_RE_STEP:   re_step_q   <= cfg_data[mbet_pkg::STEP_WIDTH-1:0];
				mbet_pkg::REG_IM_ORIGIN: im_origin_q <= $signed(cfg_data[CW-1:0]);
				mbet_pkg::REG_IM_STEP:   im_step_q   <= cfg_data[mbet_pkg::STEP_WIDTH-1:0];
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			mag_q          <= 1'b0;
			done_q         <= 1'b0;
			done_esc_q     <= 1'b0;
			result_valid_q <= 1'b0;
			count_q        <= '0;
		end else begin
			if (done_q && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			if (done_q) begin
				if (out_free) begin
					result_q.iteration_count <= count_q;
					result_q.escaped         <= done_esc_q;
					done_q                   <= 1'b0;
				end
			end else if (mag_q) begin
				// magnitude test on the new z, p_q holds y*y
				yy_q  <= p_q;
				mag_q <= 1'b0;
				if (|mag[PW:mbet_pkg::ESC_BIT]) begin
					done_q     <= 1'b1;
					done_esc_q <= 1'b1;
					state_q    <= ST_IDLE;
				end else begin
					state_q <= ST_LOOP;
				end
			end else begin
				unique case (state_q)
					ST_IDLE: begin
						if (pixel_valid && !pixel_stall) begin
							col_q   <= pixel.column;
							row_q   <= pixel.row;
							state_q <= ST_MCX;
						end
					end
					ST_MCX: begin
						p_q     <= prod[PW-1:0];
						state_q <= ST_MCY;
					end
					ST_MCY: begin
						cx_q    <= mbet_pkg::sat_coord(cx_sum);
						p_q     <= prod[PW-1:0];
						state_q <= ST_CSET;
					end
					ST_CSET: begin
						cy_q    <= mbet_pkg::sat_coord(cy_sum);
						x_q     <= '0;
						y_q     <= '0;
						xx_q    <= '0;
						yy_q    <= '0;
						count_q <= '0;
						state_q <= ST_LOOP;
					end
					ST_LOOP: begin
						if (count_q < max_iter_q) begin
							p_q     <= prod[PW-1:0];
							state_q <= ST_UPD;
						end else begin
							done_q     <= 1'b1;
							done_esc_q <= 1'b0;
							state_q    <= ST_IDLE;
						end
					end
					ST_UPD: begin
						x_q     <= mbet_pkg::sat_coord(nx_sum);
						y_q     <= mbet_pkg::sat_coord(ny_sum);
						count_q <= count_q + 1'b1;
						state_q <= ST_SQX;
					end
					ST_SQX: begin
						p_q     <= prod[PW-1:0];
						state_q <= ST_SQY;
					end
					ST_SQY: begin
						xx_q    <= p_q;
						p_q     <= prod[PW-1:0];
						mag_q   <= 1'b1;
						state_q <= ST_MAG;
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire
